// ===== src/dts_pkg.sv =====
// Shared types, token kinds and keyword table for the token scanner.
package dts_pkg;

    localparam int NKW = 28;

    // Token kinds
    localparam logic [5:0] K_SQL     = 6'd0;
    localparam logic [5:0] K_SQR     = 6'd1;
    localparam logic [5:0] K_COMMA   = 6'd2;
    localparam logic [5:0] K_SEM     = 6'd3;
    localparam logic [5:0] K_COLON   = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_OP      = 6'd6;
    localparam logic [5:0] K_CL      = 6'd7;
    localparam logic [5:0] K_PLUS    = 6'd8;
    localparam logic [5:0] K_MINUS   = 6'd9;
    localparam logic [5:0] K_MUL     = 6'd10;
    localparam logic [5:0] K_DIV     = 6'd11;
    localparam logic [5:0] K_NOT     = 6'd12;
    localparam logic [5:0] K_GE      = 6'd13;
    localparam logic [5:0] K_GT      = 6'd14;
    localparam logic [5:0] K_OR      = 6'd15;
    localparam logic [5:0] K_NE      = 6'd16;
    localparam logic [5:0] K_EQ      = 6'd17;
    localparam logic [5:0] K_COMMENT = 6'd18;
    localparam logic [5:0] K_AND     = 6'd19;
    localparam logic [5:0] K_RUID    = 6'd20;
    localparam logic [5:0] K_FUNID   = 6'd21;
    localparam logic [5:0] K_LE      = 6'd22;
    localparam logic [5:0] K_LT      = 6'd23;
    localparam logic [5:0] K_ASSIGN  = 6'd24;
    localparam logic [5:0] K_FIELDID = 6'd25;
    localparam logic [5:0] K_ID      = 6'd26;
    localparam logic [5:0] K_NUM     = 6'd27;
    localparam logic [5:0] K_RNUM    = 6'd28;
    localparam logic [5:0] K_ERR     = 6'd29;
    localparam logic [5:0] K_KW0     = 6'd30;
    localparam logic [5:0] K_END     = 6'd58;

    // Configuration register indexes
    localparam logic REG_ID_MAX    = 1'b0;
    localparam logic REG_FUNID_MAX = 1'b1;

    // Keyword text, first character in the top byte, zero padded
    localparam logic [79:0] KW_TEXT [NKW] = '{
        {"call", 48'd0}, {"record", 32'd0}, {"endrecord", 8'd0}, {"else", 48'd0},
        {"parameters"}, {"with", 48'd0}, {"end", 56'd0}, {"while", 40'd0},
        {"union", 40'd0}, {"endunion", 16'd0}, {"as", 64'd0}, {"type", 48'd0},
        {"_main", 40'd0}, {"definetype"}, {"global", 32'd0}, {"parameter", 8'd0},
        {"list", 48'd0}, {"input", 40'd0}, {"output", 32'd0}, {"int", 56'd0},
        {"real", 48'd0}, {"endwhile", 16'd0}, {"if", 64'd0}, {"then", 48'd0},
        {"endif", 40'd0}, {"read", 48'd0}, {"write", 40'd0}, {"return", 32'd0}
    };

    localparam logic [3:0] KW_LEN [NKW] = '{
        4'd4, 4'd6, 4'd9, 4'd4, 4'd10, 4'd4, 4'd3, 4'd5, 4'd5, 4'd8, 4'd2, 4'd4, 4'd5, 4'd10,
        4'd6, 4'd9, 4'd4, 4'd5, 4'd6, 4'd3, 4'd4, 4'd8, 4'd2, 4'd4, 4'd5, 4'd4, 4'd5, 4'd6
    };

    localparam int KW_MAXLEN = 10;

    typedef struct packed {
        logic [5:0]  kind;
        logic [19:0] line;
        logic [23:0] start;
        logic [7:0]  length;
    } tok_t;

endpackage

// ===== src/dfa_token_scanner.sv =====
// Top level of the byte-stream token scanner.
// Timing: a byte is registered on acceptance and scanned in the next cycle; its tokens
//   are then written into the result queue, whose count register drives m_tvalid.
// Throughput: one byte per cycle. A byte gives 0 to 3 tokens; tokens leave one per
//   cycle while m_tready is high, through an 8-entry result queue, and s_tready drops
//   unless the queue has room for three tokens from the registered byte plus three
//   from a new one.
// Reset (rst_n low, async): scanner at start state, line 1, offset 0, queue empty,
//   id_max_len 20, funid_max_len 29.
module dfa_token_scanner #(
    parameter int LINE_BITS = 20
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [5:0] token_kind, [25:6] token_line,
                                    // [49:26] token_start, [57:50] token_length
    output logic        m_tlast,    // last_of_run
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);
    import dts_pkg::*;

    localparam int DEPTH = 8;

    logic [5:0]  id_max_reg, funid_max_reg;
    logic        in_v_reg;
    logic [7:0]  ch_reg;
    tok_t [2:0]  toks;
    logic [1:0]  tok_cnt;

    // Result queue: token plus its end-of-run flag
    tok_t        q_tok [DEPTH];
    logic        q_last [DEPTH];
    logic [2:0]  wr_reg, rd_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic        pop, push;

    // Room for the item already registered plus the one being offered
    assign s_tready = ({1'b0, cnt_reg} + (in_v_reg ? 5'd3 : 5'd0) + 5'd3) <= 5'(DEPTH);
    assign push     = in_v_reg;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 4'd0);
    assign m_tdata  = {6'd0, q_tok[rd_reg].length, q_tok[rd_reg].start,
                       q_tok[rd_reg].line, q_tok[rd_reg].kind};
    assign m_tlast  = q_last[rd_reg];
    assign cnt_next = cnt_reg + (push ? {2'b0, tok_cnt} : 4'd0) - (pop ? 4'd1 : 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_max_reg    <= 6'd20;
            funid_max_reg <= 6'd29;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ID_MAX:    id_max_reg    <= cfg_data;
                REG_FUNID_MAX: funid_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else
            in_v_reg <= s_tvalid && s_tready;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            ch_reg <= s_tdata;
    end

    dts_core #(
        .LINE_BITS (LINE_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .go            (in_v_reg),
        .ch            (ch_reg),
        .id_max_len    (id_max_reg),
        .funid_max_len (funid_max_reg),
        .toks          (toks),
        .tok_cnt       (tok_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (pop)
                rd_reg <= rd_reg + 3'd1;
            if (push)
                wr_reg <= wr_reg + 3'(tok_cnt);
        end
    end

    // Up to three tokens land in consecutive slots; the last one closes the run
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < tok_cnt)
                begin
                    q_tok[wr_reg + 3'(i)]  <= toks[i];
                    q_last[wr_reg + 3'(i)] <= (2'(i) == tok_cnt - 2'd1);
                end
            end
        end
    end

endmodule

// ===== src/dts_core.sv =====
// Scanner automaton: lexeme state and the per-byte token logic.
module dts_core #(
    parameter int LINE_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [7:0]        ch,
    input  logic [5:0]        id_max_len,
    input  logic [5:0]        funid_max_len,
    output dts_pkg::tok_t [2:0] toks,
    output logic [1:0]        tok_cnt
);
    import dts_pkg::*;

    typedef enum logic [27:0] {
        ST_START  = 28'd1 << 0,  ST_GT     = 28'd1 << 1,  ST_AT1   = 28'd1 << 2,
        ST_AT2    = 28'd1 << 3,  ST_BANG   = 28'd1 << 4,  ST_EQ    = 28'd1 << 5,
        ST_CMT    = 28'd1 << 6,  ST_AMP1   = 28'd1 << 7,  ST_AMP2  = 28'd1 << 8,
        ST_HASH   = 28'd1 << 9,  ST_RUID   = 28'd1 << 10, ST_US    = 28'd1 << 11,
        ST_FUN    = 28'd1 << 12, ST_FUNDIG = 28'd1 << 13, ST_LESS  = 28'd1 << 14,
        ST_LDASH  = 28'd1 << 15, ST_LDASH2 = 28'd1 << 16, ST_BD    = 28'd1 << 17,
        ST_FIELD  = 28'd1 << 18, ST_IDL    = 28'd1 << 19, ST_IDD   = 28'd1 << 20,
        ST_INT    = 28'd1 << 21, ST_POINT  = 28'd1 << 22, ST_FR1   = 28'd1 << 23,
        ST_FR2    = 28'd1 << 24, ST_EXP    = 28'd1 << 25, ST_EXPS  = 28'd1 << 26,
        ST_EXPD   = 28'd1 << 27
    } state_t;

    localparam int LW = (LINE_BITS > 20) ? LINE_BITS : 20;

    state_t                 state_reg, state_next, bst;
    logic [LINE_BITS-1:0]   line_reg;
    logic [23:0]            pos_reg, lstart_reg;
    logic [7:0]             llen_reg, grown_len;
    logic [NKW-1:0]         kwhit_reg, kw_upd, kw_init;
    logic [LW-1:0]          line_ext;
    logic [19:0]            line_out;
    logic [23:0]            held, la, lb, sb;
    logic [5:0]             ka, kb, kc, kw_kind, fun_kind, id_kind;
    logic                   va, vb, vc, a_grown, rescan, grow, begin_lex, line_inc, kw_found;
    logic [7:0]             lc;

    function automatic logic [7:0] sat8(input logic [23:0] v);
        return (v > 24'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_low(input logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction
    function automatic logic is_alp(input logic [7:0] c);
        return is_low(c) || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_bd(input logic [7:0] c);
        return c >= "b" && c <= "d";
    endfunction
    function automatic logic is_27(input logic [7:0] c);
        return c >= "2" && c <= "7";
    endfunction

    assign line_ext  = LW'(line_reg);
    assign line_out  = (line_ext > LW'(20'hFFFFF)) ? 20'hFFFFF : line_ext[19:0];
    assign grown_len = (llen_reg == 8'd255) ? llen_reg : llen_reg + 8'd1;
    assign held      = pos_reg - 24'd1;

    // Keyword tracking: a hit bit stays set while the lexeme prefix matches.
    always_comb
    begin
        kw_found = 1'b0;
        kw_kind  = K_KW0;
        for (int k = 0; k < NKW; k++)
        begin
            kw_init[k] = (ch == KW_TEXT[k][79 -: 8]);
            kw_upd[k]  = kwhit_reg[k];
            for (int p = 0; p < KW_MAXLEN; p++)
            begin
                if (llen_reg == 8'(p) && 4'(p) < KW_LEN[k])
                    kw_upd[k] = kwhit_reg[k] && (ch == KW_TEXT[k][79 - 8*p -: 8]);
            end
            if (kwhit_reg[k] && llen_reg == {4'd0, KW_LEN[k]})
            begin
                kw_found = 1'b1;
                kw_kind  = K_KW0 + 6'(k);
            end
        end
    end

    assign fun_kind = kw_found ? kw_kind
                    : ({2'b0, llen_reg} <= {4'b0, funid_max_len} ? K_FUNID : K_ERR);
    assign id_kind  = ({2'b0, llen_reg} > {4'b0, id_max_len}) ? K_ERR : K_ID;

    always_comb
    begin
        state_next = state_reg;
        rescan     = 1'b0;
        va = 1'b0; vb = 1'b0; vc = 1'b0;
        ka = K_ERR; kb = K_ERR; kc = K_ERR;
        a_grown = 1'b0;
        sb = held; lb = 24'd1; lc = 8'd1;
        grow = 1'b0; begin_lex = 1'b0; line_inc = 1'b0;
        bst = ST_START;

        // Continue a pending lexeme
        unique case (state_reg)
            ST_START: rescan = 1'b1;
            ST_GT:
                if (ch == "=") begin va = 1'b1; ka = K_GE; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; ka = K_GT; rescan = 1'b1; end
            ST_AT1:
                if (ch == "@") begin grow = 1'b1; state_next = ST_AT2; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_AT2:
                if (ch == "@") begin va = 1'b1; ka = K_OR; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_BANG:
                if (ch == "=") begin va = 1'b1; ka = K_NE; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_EQ:
                if (ch == "=") begin va = 1'b1; ka = K_EQ; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_CMT:
                if (ch == 8'h0A) begin va = 1'b1; ka = K_COMMENT; line_inc = 1'b1; end
                else if (ch == 8'h00) begin va = 1'b1; ka = K_COMMENT; rescan = 1'b1; end
                else grow = 1'b1;
            ST_AMP1:
                if (ch == "&") begin grow = 1'b1; state_next = ST_AMP2; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_AMP2:
                if (ch == "&") begin va = 1'b1; ka = K_AND; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_HASH:
                if (is_low(ch)) begin grow = 1'b1; state_next = ST_RUID; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_RUID:
                if (is_low(ch)) grow = 1'b1;
                else begin va = 1'b1; ka = K_RUID; rescan = 1'b1; end
            ST_US:
                if (is_alp(ch)) begin grow = 1'b1; state_next = ST_FUN; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_FUN:
                if (is_alp(ch)) grow = 1'b1;
                else if (is_dig(ch)) begin grow = 1'b1; state_next = ST_FUNDIG; end
                else begin va = 1'b1; ka = fun_kind; rescan = 1'b1; end
            ST_FUNDIG:
                if (is_dig(ch)) grow = 1'b1;
                else begin va = 1'b1; ka = fun_kind; rescan = 1'b1; end
            ST_LESS:
                if (ch == "=") begin va = 1'b1; ka = K_LE; a_grown = 1'b1; grow = 1'b1; end
                else if (ch == "-") begin grow = 1'b1; state_next = ST_LDASH; end
                else begin va = 1'b1; ka = K_LT; rescan = 1'b1; end
            ST_LDASH:
                if (ch == "-") begin grow = 1'b1; state_next = ST_LDASH2; end
                else
                begin
                    // "<-x": a less-than and a minus, then x from the start
                    va = 1'b1; ka = K_LT; vb = 1'b1; kb = K_MINUS; rescan = 1'b1;
                end
            ST_LDASH2:
                if (ch == "-") begin va = 1'b1; ka = K_ASSIGN; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_BD:
                if (is_low(ch)) begin grow = 1'b1; state_next = ST_FIELD; end
                else if (is_27(ch)) begin grow = 1'b1; state_next = ST_IDL; end
                else begin va = 1'b1; ka = kw_found ? kw_kind : K_FIELDID; rescan = 1'b1; end
            ST_FIELD:
                if (is_low(ch)) grow = 1'b1;
                else begin va = 1'b1; ka = kw_found ? kw_kind : K_FIELDID; rescan = 1'b1; end
            ST_IDL:
                if (is_bd(ch)) grow = 1'b1;
                else if (is_27(ch)) begin grow = 1'b1; state_next = ST_IDD; end
                else begin va = 1'b1; ka = id_kind; rescan = 1'b1; end
            ST_IDD:
                if (is_27(ch)) grow = 1'b1;
                else begin va = 1'b1; ka = id_kind; rescan = 1'b1; end
            ST_INT:
                if (is_dig(ch)) grow = 1'b1;
                else if (ch == ".") begin grow = 1'b1; state_next = ST_POINT; end
                else begin va = 1'b1; ka = K_NUM; rescan = 1'b1; end
            ST_POINT:
                if (is_dig(ch)) begin grow = 1'b1; state_next = ST_FR1; end
                else
                begin
                    // "12.x": integer, dot, then x from the start
                    va = 1'b1; ka = K_NUM; vb = 1'b1; kb = K_DOT; rescan = 1'b1;
                end
            ST_FR1:
                if (is_dig(ch)) begin grow = 1'b1; state_next = ST_FR2; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_FR2:
                if (ch == "E") begin grow = 1'b1; state_next = ST_EXP; end
                else begin va = 1'b1; ka = K_RNUM; rescan = 1'b1; end
            ST_EXP:
                if (ch == "+" || ch == "-") begin grow = 1'b1; state_next = ST_EXPS; end
                else if (is_dig(ch)) begin grow = 1'b1; state_next = ST_EXPD; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_EXPS:
                if (is_dig(ch)) begin grow = 1'b1; state_next = ST_EXPD; end
                else begin va = 1'b1; rescan = 1'b1; end
            ST_EXPD:
                if (is_dig(ch)) begin va = 1'b1; ka = K_RNUM; a_grown = 1'b1; grow = 1'b1; end
                else begin va = 1'b1; rescan = 1'b1; end
            default: rescan = 1'b1;
        endcase

        if (va)
            state_next = ST_START;
        if (rescan)
            state_next = ST_START;

        // Lengths of the lexeme tokens
        la = a_grown ? {16'd0, grown_len} : {16'd0, llen_reg};
        if (state_reg == ST_LDASH)
            la = 24'd1;
        if (state_reg == ST_POINT)
            la = held - lstart_reg;

        // Byte seen from the start state
        if (rescan)
        begin
            case (ch)
                8'h00: begin vc = 1'b1; kc = K_END; lc = 8'd0; end
                8'h0A: line_inc = 1'b1;
                8'h09, 8'h20: ;
                "[": begin vc = 1'b1; kc = K_SQL; end
                "]": begin vc = 1'b1; kc = K_SQR; end
                ",": begin vc = 1'b1; kc = K_COMMA; end
                ";": begin vc = 1'b1; kc = K_SEM; end
                ":": begin vc = 1'b1; kc = K_COLON; end
                ".": begin vc = 1'b1; kc = K_DOT; end
                "(": begin vc = 1'b1; kc = K_OP; end
                ")": begin vc = 1'b1; kc = K_CL; end
                "+": begin vc = 1'b1; kc = K_PLUS; end
                "-": begin vc = 1'b1; kc = K_MINUS; end
                "*": begin vc = 1'b1; kc = K_MUL; end
                "/": begin vc = 1'b1; kc = K_DIV; end
                "~": begin vc = 1'b1; kc = K_NOT; end
                ">": begin begin_lex = 1'b1; bst = ST_GT; end
                "@": begin begin_lex = 1'b1; bst = ST_AT1; end
                "!": begin begin_lex = 1'b1; bst = ST_BANG; end
                "=": begin begin_lex = 1'b1; bst = ST_EQ; end
                "%": begin begin_lex = 1'b1; bst = ST_CMT; end
                "&": begin begin_lex = 1'b1; bst = ST_AMP1; end
                "#": begin begin_lex = 1'b1; bst = ST_HASH; end
                "_": begin begin_lex = 1'b1; bst = ST_US; end
                "<": begin begin_lex = 1'b1; bst = ST_LESS; end
                default:
                    if (is_dig(ch)) begin begin_lex = 1'b1; bst = ST_INT; end
                    else if (is_bd(ch)) begin begin_lex = 1'b1; bst = ST_BD; end
                    else if (is_low(ch)) begin begin_lex = 1'b1; bst = ST_FIELD; end
                    else begin vc = 1'b1; kc = K_ERR; end
            endcase
            if (begin_lex)
                state_next = bst;
        end
    end

    // Compact the tokens in order; vb only ever comes with va
    always_comb
    begin
        toks[2] = '{kind: kc, line: line_out, start: pos_reg, length: lc};
        toks[1] = vb ? '{kind: kb, line: line_out, start: sb, length: sat8(lb)} : toks[2];
        toks[0] = va ? '{kind: ka, line: line_out, start: lstart_reg, length: sat8(la)}
                     : toks[2];
        tok_cnt = 2'(va) + 2'(vb) + 2'(vc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_START;
            line_reg   <= LINE_BITS'(1);
            pos_reg    <= '0;
            lstart_reg <= '0;
            llen_reg   <= '0;
            kwhit_reg  <= '0;
        end
        else if (go)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_reg + 24'd1;
            if (line_inc && line_reg != '1)
                line_reg <= line_reg + LINE_BITS'(1);
            if (begin_lex)
            begin
                lstart_reg <= pos_reg;
                llen_reg   <= 8'd1;
                kwhit_reg  <= kw_init;
            end
            else if (grow)
            begin
                llen_reg  <= grown_len;
                kwhit_reg <= kw_upd;
            end
        end
    end

endmodule

// ===== src/dts_checker.sv =====
// Port-level checks for the token scanner, bound to the top level.
module dts_port_props (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);
    import dts_pkg::*;

    // A held result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // End-of-input token always closes its run and has zero length
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:0] == K_END |-> m_tlast && m_tdata[57:50] == 8'd0)
        else $error("end token malformed");

    // No kind beyond the end code, and padding stays zero
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:0] <= K_END && m_tdata[63:58] == 6'd0)
        else $error("bad token kind or padding");

    // Queue is empty coming out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result offered at reset release");

endmodule

bind dfa_token_scanner dts_port_props u_dts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
